@@ hw/rtl/mrpt_pkg.sv @@
package mrpt_pkg;

  // image limits
  localparam int MAX_WIDTH = 128;
  localparam int MAX_PAGES = 8;

  // derived sizes
  localparam int BYTES_MAX = MAX_WIDTH / 8;
  localparam int BP_W = (BYTES_MAX > 1) ? $clog2(BYTES_MAX) : 1;
  localparam int NB_W = $clog2(BYTES_MAX + 1);
  localparam int PG_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int NP_W = $clog2(MAX_PAGES + 1);

  // fixed field widths
  localparam int ROW_BYTES_W = 5;
  localparam int PAGES_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int COL_IDX_W = 7;
  localparam int PAGE_IDX_W = 3;

  // rows held per byte position, the eighth row comes from the input
  localparam int HELD_ROWS = 7;
  localparam int HELD_W = HELD_ROWS * 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES = 2'd1;

  // reset values of the registers
  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 5'd16;
  localparam logic [PAGES_W-1:0] PAGES_RST = 4'd8;

  localparam logic [2:0] LAST_ROW = 3'd7;
  localparam logic [2:0] LAST_COL = 3'd7;

  // one transposed 8x8 block and where it goes
  typedef struct packed {
    logic [7:0][7:0] cols;
    logic [BP_W-1:0] byte_pos;
    logic [PG_W-1:0] page;
    logic            last_byte;
    logic            last_page;
  } block_t;

  // status from the burst buffer back to the front end
  typedef struct packed {
    logic free;
  } burst_stat_t;

  // 8x8 bit transpose: column c takes bit c of every row, row r lands in bit r
  function automatic logic [7:0][7:0] transpose8(input logic [HELD_W-1:0] held,
                                                 input logic [7:0] bottom);
    logic [7:0][7:0] rows;
    logic [7:0][7:0] res;
    rows = {bottom, held};
    for (int c = 0; c < 8; c++) begin
      for (int r = 0; r < 8; r++) begin
        res[c][r] = rows[r][c];
      end
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/mrpt_burst.sv @@
module mrpt_burst
  import mrpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  block_t                blk,
  output burst_stat_t           stat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            column_byte,
  output logic [COL_IDX_W-1:0]  column_index,
  output logic [PAGE_IDX_W-1:0] page_index,
  output logic                  last_of_page,
  output logic                  last_of_frame
);

  block_t     held;
  logic [2:0] col;
  logic       xfer;
  logic       last_col;

  assign xfer = out_valid && !out_stall;
  assign last_col = (col == LAST_COL);

  // buffer can take a new block when empty or when its last column leaves now
  assign stat.free = !out_valid || (last_col && !out_stall);

  // burst control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      col <= 3'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      col <= 3'd0;
    end else if (xfer) begin
      if (last_col) begin
        out_valid <= 1'b0;
      end else begin
        col <= col + 3'd1;
      end
    end
  end

  // block payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= blk;
    end
  end

  // result fields for the current column
  assign column_byte = held.cols[col];
  assign column_index = COL_IDX_W'({held.byte_pos, col});
  assign page_index = PAGE_IDX_W'(held.page);
  assign last_of_page = held.last_byte && last_col;
  assign last_of_frame = held.last_byte && held.last_page && last_col;

endmodule

@@ hw/rtl/mono_row_to_page_transposer_top.sv @@
// Row-major 1bpp image bytes in, page-major column bytes out.
// Input channel: in_valid/in_stall with pixel_byte (bit 0 leftmost) and
// frame_start, which restarts the byte, row and page counters on that byte.
// Output channel: out_valid/out_stall with column_byte (bit 0 = page top row),
// column_index, page_index, last_of_page and last_of_frame.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index 0 = bytes per
// row, 1 = pages per image; write only while the block is idle.
// Bytes of the first seven rows of a page are stored, one per cycle. A byte of
// the eighth row is transposed with the stored rows into an eight-column burst
// buffer; the first column shows in the cycle after the transfer, then one
// column per cycle while out_stall is low. Storing bytes keep flowing during a
// burst; the next eighth-row byte is stalled until the burst's last column is
// taken, since there is a single burst buffer. Out_stall holds the current
// column in place.
// Reset clears the counters and the burst buffer and loads 16 bytes per row and
// 8 pages; stored row bytes are not cleared.
module mono_row_to_page_transposer_top
  import mrpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             pixel_byte,
  input  logic                   frame_start,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             column_byte,
  output logic [COL_IDX_W-1:0]   column_index,
  output logic [PAGE_IDX_W-1:0]  page_index,
  output logic                   last_of_page,
  output logic                   last_of_frame,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [ROW_BYTES_W-1:0] cfg_data
);

  logic [ROW_BYTES_W-1:0] row_byte_count;
  logic [PAGES_W-1:0]     page_count;
  logic [BP_W-1:0]        byte_position;
  logic [2:0]             row_in_page;
  logic [PG_W-1:0]        current_page;
  logic [BP_W-1:0]        byte_position_next;
  logic [2:0]             row_in_page_next;
  logic [PG_W-1:0]        current_page_next;
  logic [HELD_W-1:0]      row_store [BYTES_MAX];

  logic [NB_W-1:0] nbytes;
  logic [NP_W-1:0] npages;
  logic [BP_W-1:0] bp_cur;
  logic [2:0]      row_cur;
  logic [PG_W-1:0] pg_cur;
  logic [BP_W:0]   bp_inc;
  logic [PG_W:0]   pg_inc;
  logic            emit;
  logic            accept;
  logic            row_done;
  logic            load;
  block_t          blk;
  burst_stat_t     stat;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_byte_count <= ROW_BYTES_RST;
      page_count <= PAGES_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROW_BYTES) begin
        row_byte_count <= cfg_data;
      end else if (cfg_index == REG_PAGES) begin
        page_count <= cfg_data[PAGES_W-1:0];
      end
    end
  end

  // effective counts, clamped into range
  always_comb begin
    if (row_byte_count == '0) begin
      nbytes = NB_W'(1);
    end else if (row_byte_count > BYTES_MAX) begin
      nbytes = NB_W'(BYTES_MAX);
    end else begin
      nbytes = NB_W'(row_byte_count);
    end
    if (page_count == '0) begin
      npages = NP_W'(1);
    end else if (page_count > MAX_PAGES) begin
      npages = NP_W'(MAX_PAGES);
    end else begin
      npages = NP_W'(page_count);
    end
  end

  // position of this byte after frame start and wrap
  always_comb begin
    bp_cur = frame_start ? '0 : byte_position;
    row_cur = frame_start ? 3'd0 : row_in_page;
    pg_cur = frame_start ? '0 : current_page;
    if (bp_cur >= nbytes) begin
      bp_cur = '0;
    end
    if (pg_cur >= npages) begin
      pg_cur = '0;
    end
  end

  assign emit = (row_cur == LAST_ROW);
  assign in_stall = emit && !stat.free;
  assign accept = in_valid && !in_stall;
  assign load = accept && emit;

  assign bp_inc = {1'b0, bp_cur} + 1'b1;
  assign pg_inc = {1'b0, pg_cur} + 1'b1;
  assign row_done = (bp_inc >= nbytes);

  // counter advance
  always_comb begin
    byte_position_next = row_done ? '0 : bp_inc[BP_W-1:0];
    row_in_page_next = row_cur;
    current_page_next = pg_cur;
    if (row_done) begin
      if (emit) begin
        row_in_page_next = 3'd0;
        current_page_next = (pg_inc >= npages) ? '0 : pg_inc[PG_W-1:0];
      end else begin
        row_in_page_next = row_cur + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      row_in_page <= 3'd0;
      current_page <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      row_in_page <= row_in_page_next;
      current_page <= current_page_next;
    end
  end

  // store one row byte of the page
  always_ff @(posedge clk) begin
    if (accept && !emit) begin
      row_store[bp_cur][{row_cur, 3'b000} +: 8] <= pixel_byte;
    end
  end

  // transposed block for the burst buffer
  always_comb begin
    blk.cols = transpose8(row_store[bp_cur], pixel_byte);
    blk.byte_pos = bp_cur;
    blk.page = pg_cur;
    blk.last_byte = (bp_inc == nbytes);
    blk.last_page = (pg_inc == npages);
  end

  mrpt_burst u_burst (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .blk           (blk),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .column_byte   (column_byte),
    .column_index  (column_index),
    .page_index    (page_index),
    .last_of_page  (last_of_page),
    .last_of_frame (last_of_frame)
  );

`ifndef ASSERT_OFF
  // end of image is always end of a page
  a_frame_in_page: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame |-> last_of_page)
    else $error("last_of_frame without last_of_page");

  // a burst runs on after a column that is not its last
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (column_index[2:0] != LAST_COL)
      |=> out_valid && (column_index[2:0] == $past(column_index[2:0]) + 3'd1))
    else $error("burst broke off early");

  // after the last column the buffer is empty or a fresh burst starts at column 0
  a_burst_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (column_index[2:0] == LAST_COL)
      |=> !out_valid || (column_index[2:0] == 3'd0))
    else $error("new burst did not start at its first column");

  // last_of_page only on the final column of a burst
  a_page_end_col: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_page |-> (column_index[2:0] == LAST_COL))
    else $error("last_of_page away from the last column");
`endif

endmodule
